// ===== sv/bgr_pkg.sv =====
// Package for the background tile row renderer.
// Types, codes and constants shared by the bgr_* modules; no dependencies.
`default_nettype none
package bgr_pkg;

    localparam int VRAM_BYTES = 8192;
    localparam int VRAM_AW    = $clog2(VRAM_BYTES);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_RENDER = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCROLL_X      = 3'd0,
        REG_SCROLL_Y      = 3'd1,
        REG_BG_PALETTE    = 3'd2,
        REG_BG_ENABLE     = 3'd3,
        REG_BG_MAP_HIGH   = 3'd4,
        REG_TILES_UNSIGNED = 3'd5
    } cfg_index_t;

    localparam logic [7:0] PALETTE_RESET = 8'd252;

    typedef struct packed {
        logic [7:0] scroll_x;
        logic [7:0] scroll_y;
        logic [7:0] bg_palette;
        logic       bg_enable;
        logic       bg_map_high;
        logic       bg_tiles_unsigned;
    } cfg_t;

    typedef struct packed {
        logic               en;
        logic               we;
        logic [VRAM_AW-1:0] addr;
        logic [7:0]         wdata;
    } vram_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAP,
        ST_LO,
        ST_HI,
        ST_LATCH,
        ST_SHADE,
        ST_FINISH
    } fetch_state_t;

endpackage
`default_nettype wire

// ===== sv/bgr_cfg.sv =====
// Configuration registers of the background renderer.
// Depends on bgr_pkg for the register index codes and the cfg_t bundle.
`default_nettype none
module bgr_cfg (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [bgr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [bgr_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output bgr_pkg::cfg_t                      cfg
);
    import bgr_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.scroll_x          <= '0;
            cfg_reg.scroll_y          <= '0;
            cfg_reg.bg_palette        <= PALETTE_RESET;
            cfg_reg.bg_enable         <= 1'b1;
            cfg_reg.bg_map_high       <= 1'b0;
            cfg_reg.bg_tiles_unsigned <= 1'b1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_SCROLL_X:       cfg_reg.scroll_x          <= cfg_wdata;
                REG_SCROLL_Y:       cfg_reg.scroll_y          <= cfg_wdata;
                REG_BG_PALETTE:     cfg_reg.bg_palette        <= cfg_wdata;
                REG_BG_ENABLE:      cfg_reg.bg_enable         <= cfg_wdata[0];
                REG_BG_MAP_HIGH:    cfg_reg.bg_map_high       <= cfg_wdata[0];
                REG_TILES_UNSIGNED: cfg_reg.bg_tiles_unsigned <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

// ===== sv/bgr_vram.sv =====
// Single-port video memory, 8 KiB, registered read data.
// Depends on bgr_pkg for the request bundle and the address width.
`default_nettype none
module bgr_vram (
    input  wire logic        aclk,
    input  bgr_pkg::vram_req_t req,
    output logic [7:0]       rdata
);
    import bgr_pkg::*;

    logic [7:0] mem [VRAM_BYTES];
    logic [7:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.en) begin
            if (req.we) begin
                mem[req.addr] <= req.wdata;
            end else begin
                rdata_reg <= mem[req.addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ===== sv/bgr_fetch.sv =====
// Fetch sequencer: takes input transfers, drives the video memory port and
// builds the eight shades one pixel per cycle between tile fetches. Depends on bgr_pkg.
`default_nettype none
module bgr_fetch (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  bgr_pkg::cfg_t                    cfg,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic                        s_cmd,
    input  wire logic [bgr_pkg::VRAM_AW-1:0] s_vram_addr,
    input  wire logic [7:0]                  s_vram_data,
    input  wire logic [7:0]                  s_line,
    input  wire logic [4:0]                  s_column,
    output bgr_pkg::vram_req_t               vram_req,
    input  wire logic [7:0]                  vram_rdata,
    input  wire logic                        out_free,
    output logic                             res_valid,
    output logic [15:0]                      res_shades
);
    import bgr_pkg::*;

    fetch_state_t       state_reg, state_next;
    logic [2:0]         pix_reg, pix_next;
    logic [4:0]         column_reg;
    logic [7:0]         by_reg;
    logic [VRAM_AW-1:0] pat_addr_reg;
    logic [7:0]         lo_reg;
    logic [7:0]         hi_reg;
    logic [15:0]        shades_reg;

    logic               accept;
    logic [7:0]         bx;
    logic [2:0]         bit_sel;
    logic [1:0]         colour;
    logic [1:0]         shade;
    logic [VRAM_AW-1:0] map_addr;
    logic [VRAM_AW-1:0] pat_addr;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // shared coordinate adder, one pixel per use
    assign bx = {column_reg, pix_reg} + cfg.scroll_x;

    // map at 0x1800/0x1C00 offset: {11, map_high, row of tiles, tile column}
    assign map_addr = {2'b11, cfg.bg_map_high, by_reg[7:3], bx[7:3]};

    // signed codes: 0x1000 + code*16 for code < 128, 0x0800 + (code-128)*16 otherwise
    assign pat_addr = {~cfg.bg_tiles_unsigned & ~vram_rdata[7], vram_rdata[7],
                       vram_rdata[6:0], by_reg[2:0], 1'b0};

    assign bit_sel = ~bx[2:0];
    assign colour  = {hi_reg[bit_sel], lo_reg[bit_sel]};
    assign shade   = cfg.bg_palette[{colour, 1'b0} +: 2];

    always_comb begin
        state_next     = state_reg;
        pix_next       = pix_reg;
        vram_req.en    = 1'b0;
        vram_req.we    = 1'b0;
        vram_req.addr  = map_addr;
        vram_req.wdata = s_vram_data;
        res_valid      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_cmd == CMD_WRITE) begin
                        vram_req.en   = 1'b1;
                        vram_req.we   = 1'b1;
                        vram_req.addr = s_vram_addr;
                    end else if (cfg.bg_enable) begin
                        state_next = ST_MAP;
                        pix_next   = '0;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_MAP: begin
                vram_req.en = 1'b1;
                state_next  = ST_LO;
            end
            ST_LO: begin
                vram_req.en   = 1'b1;
                vram_req.addr = pat_addr;
                state_next    = ST_HI;
            end
            ST_HI: begin
                vram_req.en   = 1'b1;
                vram_req.addr = pat_addr_reg | VRAM_AW'(1);
                state_next    = ST_LATCH;
            end
            ST_LATCH: begin
                state_next = ST_SHADE;
            end
            ST_SHADE: begin
                if (pix_reg == 3'd7) begin
                    state_next = ST_FINISH;
                end else begin
                    pix_next = pix_reg + 3'd1;
                    // next pixel crosses into the following tile
                    if (bx[2:0] == 3'd7) begin
                        state_next = ST_MAP;
                    end
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    res_valid  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pix_reg   <= '0;
        end else begin
            state_reg <= state_next;
            pix_reg   <= pix_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            column_reg <= s_column;
            by_reg     <= s_line + cfg.scroll_y;
            shades_reg <= '0;
        end
        if (state_reg == ST_LO) begin
            pat_addr_reg <= pat_addr;
        end
        if (state_reg == ST_HI) begin
            lo_reg <= vram_rdata;
        end
        if (state_reg == ST_LATCH) begin
            hi_reg <= vram_rdata;
        end
        if (state_reg == ST_SHADE) begin
            shades_reg <= {shades_reg[13:0], shade};
        end
    end

    assign res_shades = shades_reg;

`ifndef SYNTHESIS
    a_write_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        vram_req.we |-> (state_reg == ST_IDLE))
        else $error("video memory write outside idle");

    a_render_starts_fetch: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_cmd == CMD_RENDER && cfg.bg_enable) |=> (state_reg == ST_MAP))
        else $error("enabled render did not start with a map read");

    a_shade_after_fetch: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SHADE && $past(state_reg) != ST_SHADE)
            |-> ($past(state_reg) == ST_LATCH))
        else $error("shading began without a completed tile fetch");

    a_finish_after_last_pixel: assert property (@(posedge aclk) disable iff (!aresetn)
        ($rose(state_reg == ST_FINISH) && $past(state_reg) == ST_SHADE)
            |-> ($past(pix_reg) == 3'd7))
        else $error("result finished before all eight pixels");
`endif

endmodule
`default_nettype wire

// ===== sv/background_tile_row_renderer.sv =====
// Background tile row renderer: 8 KiB video memory, write and render transfers,
// eight 2-bit shades per render. A render with the background on costs, per
// tile, one map read and two pattern reads on the single video memory port plus
// a latch state, then one cycle per pixel through the shared coordinate adder
// and palette lookup. A render with the background off skips the fetch and
// returns all-zero shades. The result sits in an output register, so the next
// transfer is taken while it waits. Memory content is undefined until written.
`default_nettype none
module background_tile_row_renderer (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_wr_en,
    input  wire logic [bgr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [bgr_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic                         s_cmd,
    input  wire logic [12:0]                  s_vram_addr,
    input  wire logic [7:0]                   s_vram_data,
    input  wire logic [7:0]                   s_line,
    input  wire logic [4:0]                   s_column,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [15:0]                       m_pixel_shades
);
    import bgr_pkg::*;

    cfg_t        cfg;
    vram_req_t   vram_req;
    logic [7:0]  vram_rdata;
    logic        out_free;
    logic        res_valid;
    logic [15:0] res_shades;
    logic        m_valid_reg;
    logic [15:0] m_shades_reg;

    bgr_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    bgr_vram u_vram (
        .aclk  (aclk),
        .req   (vram_req),
        .rdata (vram_rdata)
    );

    bgr_fetch u_fetch (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cmd       (s_cmd),
        .s_vram_addr (s_vram_addr),
        .s_vram_data (s_vram_data),
        .s_line      (s_line),
        .s_column    (s_column),
        .vram_req    (vram_req),
        .vram_rdata  (vram_rdata),
        .out_free    (out_free),
        .res_valid   (res_valid),
        .res_shades  (res_shades)
    );

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            m_shades_reg <= res_shades;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_pixel_shades = m_shades_reg;

endmodule
`default_nettype wire
